>>> design/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types, constants and offset helpers for the cycling power
// measurement parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cpm_pkg;

  // Byte position counter and packet length widths
  localparam int unsigned POS_W = 5;
  localparam int unsigned LEN_W = POS_W + 1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Flag bits of the measurement flags word
  localparam int unsigned FLAG_BALANCE_BIT = 0;
  localparam int unsigned FLAG_TORQUE_BIT  = 2;
  localparam int unsigned FLAG_WHEEL_BIT   = 4;
  localparam int unsigned FLAG_CRANK_BIT   = 5;

  // Field lengths in bytes
  localparam logic [LEN_W-1:0] HEADER_LEN  = LEN_W'(4);
  localparam logic [LEN_W-1:0] BALANCE_LEN = LEN_W'(1);
  localparam logic [LEN_W-1:0] TORQUE_LEN  = LEN_W'(2);
  localparam logic [LEN_W-1:0] WHEEL_LEN   = LEN_W'(6);
  localparam logic [LEN_W-1:0] CRANK_LEN   = LEN_W'(4);

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_SHORT       = 2'd1,
    STATUS_WHEEL_TRUNC = 2'd2,
    STATUS_CRANK_TRUNC = 2'd3
  } status_t;

  // Byte write request towards the field store
  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } cpm_capture_t;

  // Assembled little-endian field words
  typedef struct packed {
    logic [15:0] flags;
    logic [15:0] power;
    logic [31:0] wheel_count;
    logic [15:0] wheel_time;
    logic [15:0] crank_count;
    logic [15:0] crank_time;
  } cpm_words_t;

  // Byte offset of the wheel revolution data
  function automatic logic [LEN_W-1:0] wheel_offset(input logic [15:0] flags);
    logic [LEN_W-1:0] off;
    off = HEADER_LEN;
    if (flags[FLAG_BALANCE_BIT]) off = off + BALANCE_LEN;
    if (flags[FLAG_TORQUE_BIT])  off = off + TORQUE_LEN;
    return off;
  endfunction

  // Byte offset of the crank revolution data
  function automatic logic [LEN_W-1:0] crank_offset(input logic [15:0] flags);
    logic [LEN_W-1:0] off;
    off = wheel_offset(flags);
    if (flags[FLAG_WHEEL_BIT]) off = off + WHEEL_LEN;
    return off;
  endfunction

endpackage

`default_nettype wire

>>> design/cpm_in_if.sv
// ----------------------------------------------------------------------------
// cpm_in_if
// Byte stream channel: one notification byte per transfer, last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
  modport monitor (input valid, input data_byte, input last_byte, input ready);
endinterface

`default_nettype wire

>>> design/cpm_out_if.sv
// ----------------------------------------------------------------------------
// cpm_out_if
// Record channel: one parsed measurement record per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [14:0] power_watts;
  logic        wheel_present;
  logic [31:0] wheel_revolutions;
  logic [14:0] wheel_event_time;
  logic        crank_present;
  logic [15:0] crank_revolutions;
  logic [15:0] crank_event_time;

  modport source (
    output valid, output status, output power_watts,
    output wheel_present, output wheel_revolutions, output wheel_event_time,
    output crank_present, output crank_revolutions, output crank_event_time,
    input ready
  );
  modport sink (
    input valid, input status, input power_watts,
    input wheel_present, input wheel_revolutions, input wheel_event_time,
    input crank_present, input crank_revolutions, input crank_event_time,
    output ready
  );
  modport monitor (
    input valid, input status, input power_watts,
    input wheel_present, input wheel_revolutions, input wheel_event_time,
    input crank_present, input crank_revolutions, input crank_event_time,
    input ready
  );
endinterface

`default_nettype wire

>>> design/cycling_power_measurement_parser.sv
// ----------------------------------------------------------------------------
// cycling_power_measurement_parser
// Parses a cycling power measurement notification byte by byte and emits
// one record with status on the last byte.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        data_byte, last_byte
//  out_chan  out  valid/ready        status, power, wheel and crank fields
//  cfg_*     in   cfg_we (no ready)  cfg_wdata = enable
//
//  One byte is taken per cycle; the record for a last byte appears on
//  out_chan in the next cycle. The byte path is a single register stage:
//  position counter and field words on one side, the record register on
//  the other. in_chan stalls only while a record waits and out_chan.ready
//  is low. Synchronous reset clears enable, position and the record valid.
// ----------------------------------------------------------------------------
`default_nettype none

module cycling_power_measurement_parser
  import cpm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  cpm_in_if.sink     in_chan,
  cpm_out_if.source  out_chan
);

  logic             enable_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             in_ready;
  logic             in_xfer;
  logic             emit;
  cpm_capture_t     cap;
  cpm_words_t       words_nxt;
  logic [LEN_W-1:0] len;

  status_t          status_nxt;
  logic [14:0]      power_nxt;
  logic             wheel_ok;
  logic             crank_ok;

  logic             out_valid_r;
  status_t          status_r;
  logic [14:0]      power_r;
  logic             wheel_present_r;
  logic [31:0]      wheel_count_r;
  logic [14:0]      wheel_time_r;
  logic             crank_present_r;
  logic [15:0]      crank_count_r;
  logic [15:0]      crank_time_r;

  // Accept while the record register is free or being drained
  assign in_ready      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = in_ready;
  assign in_xfer       = in_chan.valid && in_ready;
  assign emit          = in_xfer && enable_r && in_chan.last_byte;

  assign cap.we   = in_xfer && enable_r;
  assign cap.pos  = pos_r;
  assign cap.data = in_chan.data_byte;

  cpm_fields u_fields (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap),
    .words_nxt (words_nxt)
  );

  // Advance the byte position, saturating; restart on last byte or disable
  always_comb begin
    pos_nxt = pos_r;
    if (in_xfer) begin
      if (!enable_r || in_chan.last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // Judge completeness of the packet from its length and flags
  always_comb begin
    len        = LEN_W'(pos_r) + LEN_W'(1);
    status_nxt = STATUS_OK;
    wheel_ok   = 1'b0;
    crank_ok   = 1'b0;
    if (len < HEADER_LEN) begin
      status_nxt = STATUS_SHORT;
    end else if (words_nxt.flags[FLAG_WHEEL_BIT] &&
                 ((wheel_offset(words_nxt.flags) + WHEEL_LEN) > len)) begin
      status_nxt = STATUS_WHEEL_TRUNC;
    end else begin
      wheel_ok = words_nxt.flags[FLAG_WHEEL_BIT];
      if (words_nxt.flags[FLAG_CRANK_BIT] &&
          ((crank_offset(words_nxt.flags) + CRANK_LEN) > len)) begin
        status_nxt = STATUS_CRANK_TRUNC;
      end else begin
        crank_ok = words_nxt.flags[FLAG_CRANK_BIT];
      end
    end
    // Clamp negative power to zero; power is also zero unless the status is OK
    power_nxt = '0;
    if (status_nxt == STATUS_OK && !words_nxt.power[15]) begin
      power_nxt = words_nxt.power[14:0];
    end
  end

  // Hold control state: enable, position, record valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      pos_r <= pos_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the record register
  always_ff @(posedge clk) begin
    if (emit) begin
      status_r        <= status_nxt;
      power_r         <= power_nxt;
      wheel_present_r <= wheel_ok;
      wheel_count_r   <= wheel_ok ? words_nxt.wheel_count : '0;
      wheel_time_r    <= wheel_ok ? words_nxt.wheel_time[15:1] : '0;
      crank_present_r <= crank_ok;
      crank_count_r   <= crank_ok ? words_nxt.crank_count : '0;
      crank_time_r    <= crank_ok ? words_nxt.crank_time : '0;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.status            = status_r;
  assign out_chan.power_watts       = power_r;
  assign out_chan.wheel_present     = wheel_present_r;
  assign out_chan.wheel_revolutions = wheel_count_r;
  assign out_chan.wheel_event_time  = wheel_time_r;
  assign out_chan.crank_present     = crank_present_r;
  assign out_chan.crank_revolutions = crank_count_r;
  assign out_chan.crank_event_time  = crank_time_r;

endmodule

`default_nettype wire

>>> design/cpm_fields.sv
// ----------------------------------------------------------------------------
// cpm_fields
// Field store: steers each payload byte into the flags, power, wheel and
// crank words by its position and the flags already received.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_fields
  import cpm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cpm_capture_t cap,
  output cpm_words_t        words_nxt
);

  cpm_words_t       words_r;
  logic [LEN_W-1:0] pos_ext;
  logic [LEN_W-1:0] wheel_off;
  logic [LEN_W-1:0] crank_off;
  logic [LEN_W-1:0] wheel_idx;
  logic [LEN_W-1:0] crank_idx;
  logic             in_wheel;
  logic             in_crank;

  // Locate the byte within the optional sections
  always_comb begin
    pos_ext   = LEN_W'(cap.pos);
    wheel_off = wheel_offset(words_r.flags);
    crank_off = crank_offset(words_r.flags);
    wheel_idx = pos_ext - wheel_off;
    crank_idx = pos_ext - crank_off;
    in_wheel  = words_r.flags[FLAG_WHEEL_BIT] && (pos_ext >= wheel_off) &&
                (pos_ext < (wheel_off + WHEEL_LEN));
    in_crank  = words_r.flags[FLAG_CRANK_BIT] && (pos_ext >= crank_off) &&
                (pos_ext < (crank_off + CRANK_LEN));
  end

  // Merge the byte into its word
  always_comb begin
    words_nxt = words_r;
    if (cap.we) begin
      if (pos_ext < LEN_W'(2)) begin
        words_nxt.flags[{cap.pos[0], 3'b000} +: 8] = cap.data;
      end else if (pos_ext < HEADER_LEN) begin
        words_nxt.power[{cap.pos[0], 3'b000} +: 8] = cap.data;
      end else begin
        if (in_wheel) begin
          if (wheel_idx < LEN_W'(4)) begin
            words_nxt.wheel_count[{wheel_idx[1:0], 3'b000} +: 8] = cap.data;
          end else begin
            words_nxt.wheel_time[{wheel_idx[0], 3'b000} +: 8] = cap.data;
          end
        end
        if (in_crank) begin
          if (crank_idx < LEN_W'(2)) begin
            words_nxt.crank_count[{crank_idx[0], 3'b000} +: 8] = cap.data;
          end else begin
            words_nxt.crank_time[{crank_idx[0], 3'b000} +: 8] = cap.data;
          end
        end
      end
    end
  end

  // Hold the field words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
    end else begin
      words_r <= words_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/cpm_checker.sv
// ----------------------------------------------------------------------------
// cpm_checker
// Port-level checks on the record channel of the parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_checker
  import cpm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [14:0] out_power,
  input wire logic        out_wheel_present,
  input wire logic [31:0] out_wheel_count,
  input wire logic [14:0] out_wheel_time,
  input wire logic        out_crank_present,
  input wire logic [15:0] out_crank_count
);

  // A waiting record stays until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("record dropped while stalled");

  // A new record only follows a byte transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("record without a byte transfer");

  // Short packet carries nothing but its status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_SHORT |->
      out_power == '0 && !out_wheel_present && !out_crank_present)
    else $error("short packet with field data");

  // Truncated data leaves power and the crank section empty
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid &&
    (out_status == STATUS_WHEEL_TRUNC || out_status == STATUS_CRANK_TRUNC) |->
      out_power == '0 && !out_crank_present && out_crank_count == '0)
    else $error("truncated packet with power or crank data");

  // Absent wheel data reads as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wheel_present |->
      out_wheel_count == '0 && out_wheel_time == '0)
    else $error("wheel fields set without wheel data");

endmodule

bind cycling_power_measurement_parser cpm_checker u_cpm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_status        (out_chan.status),
  .out_power         (out_chan.power_watts),
  .out_wheel_present (out_chan.wheel_present),
  .out_wheel_count   (out_chan.wheel_revolutions),
  .out_wheel_time    (out_chan.wheel_event_time),
  .out_crank_present (out_chan.crank_present),
  .out_crank_count   (out_chan.crank_revolutions)
);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cycling power measurement parser. Notification
// bytes are streamed into in_chan under several idling patterns. A predictor
// follows the byte stream and the enable register and builds the expected
// record for every packet end. Records taken from out_chan are compared field
// by field against the oldest expected record.
// ----------------------------------------------------------------------------

module testbench
  import cpm_pkg::*;
();

  // One parsed measurement record
  typedef struct packed {
    status_t     status;
    logic [14:0] power_watts;
    logic        wheel_present;
    logic [31:0] wheel_revolutions;
    logic [14:0] wheel_event_time;
    logic        crank_present;
    logic [15:0] crank_revolutions;
    logic [15:0] crank_event_time;
  } record_t;

  // One notification byte with its last-byte mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  cpm_in_if  in_if ();
  cpm_out_if out_if ();

  cycling_power_measurement_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  // Stimulus and expectation stores
  stream_byte_t byte_queue[$];
  record_t      expected_records[$];
  int           bytes_queued;
  int           mismatch_count;
  int           cycle_count;
  int           send_idle_pct;
  int           stall_pct;
  bit           byte_taken;

  // Predicted parser state
  logic        parser_enable;
  logic [4:0]  pos_q;
  logic [15:0] flags_q;
  logic [15:0] power_q;
  logic [31:0] wrevs_q;
  logic [15:0] wtime_q;
  logic [15:0] crevs_q;
  logic [15:0] ctime_q;

  // Advance the parser by one accepted byte; queue a record on a packet end
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int      p;
    int      len;
    int      wo;
    int      co;
    record_t rec;
    if (!parser_enable) begin
      pos_q = '0;
      return;
    end
    p = pos_q;
    if (p < 2) flags_q[8*p +: 8] = b;
    else if (p < 4) power_q[8*(p-2) +: 8] = b;
    wo = 4 + (flags_q[FLAG_BALANCE_BIT] ? 1 : 0) + (flags_q[FLAG_TORQUE_BIT] ? 2 : 0);
    co = wo + (flags_q[FLAG_WHEEL_BIT] ? 6 : 0);
    if (p >= 4) begin
      if (flags_q[FLAG_WHEEL_BIT] && p >= wo && p < wo + 6) begin
        if (p < wo + 4) wrevs_q[8*(p-wo) +: 8] = b;
        else wtime_q[8*(p-wo-4) +: 8] = b;
      end
      if (flags_q[FLAG_CRANK_BIT] && p >= co && p < co + 4) begin
        if (p < co + 2) crevs_q[8*(p-co) +: 8] = b;
        else ctime_q[8*(p-co-2) +: 8] = b;
      end
    end
    if (pos_q != POS_MAX) pos_q = pos_q + 5'd1;
    if (!last) return;

    // Packet end: build the record
    len = p + 1;
    pos_q = '0;
    rec = '0;
    if (len < 4) begin
      rec.status = STATUS_SHORT;
    end else if (flags_q[FLAG_WHEEL_BIT] && wo + 6 > len) begin
      rec.status = STATUS_WHEEL_TRUNC;
    end else begin
      if (flags_q[FLAG_WHEEL_BIT]) begin
        rec.wheel_present     = 1'b1;
        rec.wheel_revolutions = wrevs_q;
        rec.wheel_event_time  = wtime_q[15:1];
      end
      if (flags_q[FLAG_CRANK_BIT] && co + 4 > len) begin
        rec.status = STATUS_CRANK_TRUNC;
      end else begin
        rec.status = STATUS_OK;
        if (flags_q[FLAG_CRANK_BIT]) begin
          rec.crank_present     = 1'b1;
          rec.crank_revolutions = crevs_q;
          rec.crank_event_time  = ctime_q;
        end
      end
    end
    // Clamp negative power to zero; power is also zero unless the status is OK
    if (rec.status == STATUS_OK && !power_q[15]) rec.power_watts = power_q[14:0];
    expected_records.push_back(rec);
  endtask

  function automatic string format_record(input record_t r);
    return $sformatf("status %0d power %0d wheel %0b/%08h/%04h crank %0b/%04h/%04h",
                     r.status, r.power_watts, r.wheel_present, r.wheel_revolutions,
                     r.wheel_event_time, r.crank_present, r.crank_revolutions,
                     r.crank_event_time);
  endfunction

  // Queue one packet; fill < 0 gives random payload bytes after the header
  task automatic queue_packet(input logic [15:0] flags, input logic [15:0] power,
                              input int len, input int fill, input bit close);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (i)
        0: b = flags[7:0];
        1: b = flags[15:8];
        2: b = power[7:0];
        3: b = power[15:8];
        default: b = (fill < 0) ? 8'($urandom) : fill[7:0];
      endcase
      byte_queue.push_back('{data: b, last: close && (i == len - 1)});
    end
    bytes_queued += len;
  endtask

  // Mostly well-formed packets, with extra bytes, long, truncated and short ones
  task automatic random_packet();
    logic [15:0] flags;
    int          need;
    int          kind;
    int          len;
    flags = 16'($urandom);
    need = 4 + (flags[FLAG_BALANCE_BIT] ? 1 : 0) + (flags[FLAG_TORQUE_BIT] ? 2 : 0)
         + (flags[FLAG_WHEEL_BIT] ? 6 : 0) + (flags[FLAG_CRANK_BIT] ? 4 : 0);
    kind = $urandom_range(0, 99);
    if (kind < 60) len = need;
    else if (kind < 72) len = need + $urandom_range(1, 6);
    else if (kind < 80) len = $urandom_range(31, 40);
    else if (kind < 90) len = $urandom_range(1, need - 1);
    else len = $urandom_range(1, 3);
    queue_packet(flags, 16'($urandom), len, -1, 1'b1);
  endtask

  // Wait until every byte is taken and every record checked, then let it settle
  task automatic drain();
    while (byte_queue.size() != 0 || expected_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Byte driver: hold an offered byte until taken, idle at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !byte_taken)) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.data_byte <= byte_queue[0].data;
        in_if.last_byte <= byte_queue[0].last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Record receiver: stall at random
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: track configuration, check records, predict from taken bytes
  always @(posedge clk) begin
    record_t got;
    record_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!rst_n) begin
      byte_taken = 1'b0;
    end else begin
      if (cfg_we) parser_enable = cfg_wdata;
      if (out_if.valid && out_if.ready) begin
        got.status            = status_t'(out_if.status);
        got.power_watts       = out_if.power_watts;
        got.wheel_present     = out_if.wheel_present;
        got.wheel_revolutions = out_if.wheel_revolutions;
        got.wheel_event_time  = out_if.wheel_event_time;
        got.crank_present     = out_if.crank_present;
        got.crank_revolutions = out_if.crank_revolutions;
        got.crank_event_time  = out_if.crank_event_time;
        if (expected_records.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected record: %s", format_record(got));
        end else begin
          want = expected_records.pop_front();
          if (got.status !== want.status || got.power_watts !== want.power_watts ||
              got.wheel_present !== want.wheel_present ||
              got.wheel_revolutions !== want.wheel_revolutions ||
              got.wheel_event_time !== want.wheel_event_time ||
              got.crank_present !== want.crank_present ||
              got.crank_revolutions !== want.crank_revolutions ||
              got.crank_event_time !== want.crank_event_time) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("record mismatch at cycle %0d", cycle_count);
              $display("  expected %s", format_record(want));
              $display("  actual   %s", format_record(got));
            end
          end
        end
      end
      byte_taken = in_if.valid && in_if.ready;
      if (byte_taken) begin
        void'(byte_queue.pop_front());
        parse_byte(in_if.data_byte, in_if.last_byte);
      end
    end
  end

  // Stimulus sequence
  initial begin
    int target;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    bytes_queued    = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    byte_taken      = 1'b0;
    parser_enable   = 1'b0;
    pos_q           = '0;
    flags_q         = '0;
    power_q         = '0;
    wrevs_q         = '0;
    wtime_q         = '0;
    crevs_q         = '0;
    ctime_q         = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: a whole packet must leave no record
    queue_packet(16'h0010, 16'h0000, 6, -1, 1'b1);
    drain();
    write_enable(1'b1);

    // Directed packets: short, largest power, all-ones fields, truncations
    queue_packet(16'h0000, 16'h0000, 1, 0, 1'b1);
    queue_packet(16'h0000, 16'h7FFF, 4, 0, 1'b1);
    queue_packet(16'h0030, 16'hFFFF, 14, 8'hFF, 1'b1);
    queue_packet(16'h0015, 16'h1234, 5, 8'hA5, 1'b1);
    queue_packet(16'h0035, 16'h8000, 13, 8'h5A, 1'b1);
    drain();

    // Random packets under each idling pattern, twice over
    for (int round = 0; round < 2; round++) begin
      for (int mode = 0; mode < 4; mode++) begin
        case (mode)
          0: begin send_idle_pct = 0;  stall_pct = 0;  end
          1: begin send_idle_pct = 82; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 82; end
          default: begin send_idle_pct = 25; stall_pct = 25; end
        endcase
        target = bytes_queued + 170;
        while (bytes_queued < target) random_packet();
        drain();
        // Drop enable part way into a packet, feed ignored bytes, then resume
        if (mode == 1 || mode == 3) begin
          queue_packet(16'($urandom), 16'($urandom), $urandom_range(1, 12), -1, 1'b0);
          drain();
          write_enable(1'b0);
          queue_packet(16'($urandom), 16'($urandom), $urandom_range(1, 8), -1, 1'b1);
          queue_packet(16'($urandom), 16'($urandom), $urandom_range(1, 8), -1, 1'b0);
          drain();
          write_enable(1'b1);
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_records.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
design/cpm_pkg.sv
design/cpm_in_if.sv
design/cpm_out_if.sv
design/cpm_fields.sv
design/cycling_power_measurement_parser.sv
design/cpm_checker.sv
bench/testbench.sv
